// ===== design/nv12_letterbox_to_rgb_unit_assert.svh =====
// assertion macros for the nv12 letterbox converter
`ifndef NV12_LETTERBOX_TO_RGB_UNIT_ASSERT_SVH
`define NV12_LETTERBOX_TO_RGB_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NLB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define NLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/nlb_pkg.sv =====
// shared widths, constants, types and the rounding function of the nv12 letterbox converter
package nlb_pkg;

  localparam int SRC_W   = 8;
  localparam int DST_W   = 11;
  localparam int ADDR_W  = 15;
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 10;
  localparam int COLOR_W = 16;
  localparam int PIDX_W  = 20;
  localparam int CFG_W   = 11;
  localparam int QW      = 8;
  localparam int NUM_W   = COORD_W + SRC_W;
  localparam int PLANE_W = 2 * SRC_W;
  localparam int PROD_W  = 25;
  localparam int ACC_W   = 27;

  localparam int MAX_SRC_WIDTH_DEF  = 128;
  localparam int MAX_SRC_HEIGHT_DEF = 128;
  localparam int MAX_DST_SIZE_DEF   = 1024;

  localparam logic [SRC_W-1:0] RESET_SRC = 8'd128;
  localparam logic [DST_W-1:0] RESET_DST = 11'd128;

  localparam logic signed [15:0] COEF_RV = 16'sd22970;
  localparam logic signed [15:0] COEF_GU = 16'sd5638;
  localparam logic signed [15:0] COEF_GV = 16'sd11700;
  localparam logic signed [15:0] COEF_BU = 16'sd29032;

  localparam logic signed [ACC_W-1:0] CLAMP_HI = 27'sd4177920;
  localparam logic [COLOR_W-1:0] COLOR_MAX = 16'd65280;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_DEST_WIDTH    = 2'd2,
    REG_DEST_HEIGHT   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_CONVERT = 1'b1
  } op_t;

  typedef struct packed {
    logic               busy;
    logic               ok;
    logic [SRC_W-1:0]   sw;
    logic [SRC_W-1:0]   sh;
    logic [DST_W-1:0]   dw;
    logic [DST_W-1:0]   dh;
    logic [DST_W-1:0]   scw;
    logic [DST_W-1:0]   sch;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [PLANE_W-1:0] plane;
  } geo_t;

  // clamp a q.14 sum to 0..255 and round half up to q8.8
  function automatic logic [COLOR_W-1:0] to_q88(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = acc + 27'sd32;
    if (acc <= 0) return '0;
    if (acc >= CLAMP_HI) return COLOR_MAX;
    return t[COLOR_W+5:6];
  endfunction

endpackage

// ===== design/nlb_ifs.sv =====
// channel interfaces: pixel and write items, results, configuration writes
interface nlb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [nlb_pkg::ADDR_W-1:0]    byte_address;
  logic [nlb_pkg::BYTE_W-1:0]    byte_value;
  logic [nlb_pkg::COORD_W-1:0]   dest_x;
  logic [nlb_pkg::COORD_W-1:0]   dest_y;
  modport source (output valid, op, byte_address, byte_value, dest_x, dest_y, input ready);
  modport sink (input valid, op, byte_address, byte_value, dest_x, dest_y, output ready);
endinterface

interface nlb_out_if;
  logic                          valid;
  logic                          ready;
  logic [nlb_pkg::COLOR_W-1:0]   red;
  logic [nlb_pkg::COLOR_W-1:0]   green;
  logic [nlb_pkg::COLOR_W-1:0]   blue;
  logic                          is_padding;
  logic [nlb_pkg::PIDX_W-1:0]    pixel_index;
  logic                          size_error;
  modport source (output valid, red, green, blue, is_padding, pixel_index, size_error,
                  input ready);
  modport sink (input valid, red, green, blue, is_padding, pixel_index, size_error,
                output ready);
endinterface

interface nlb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    index;
  logic [nlb_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/nv12_letterbox_to_rgb_unit.sv =====
// top level: nv12 frame store with letterboxing nearest-sample bt.601 rgb conversion
// One item enters per cycle while ready is high. A write beat (op 0) stores one NV12
// byte; a convert beat (op 1) returns one result: red, green, blue in unsigned Q8.8
// (full-range BT.601, clamped to 0..255), a padding flag for the letterbox border,
// the planar pixel index and a size error flag. Writes travel the same pipeline
// and land in the store at the stage where conversions read it, so beats take
// effect strictly in order. The pipeline is 14 register stages, a registered store
// read, a multiply stage and the output register; the 8 middle stages are a
// pipelined restoring divider, one quotient bit per stage for both axes. After
// reset and after every configuration write the geometry is rederived, for valid
// sizes by a sequential 11-step divider, and pixel input is held off (ready low)
// while it runs. There is no clearing pass: the store must be written before it is
// read. A stalled output freezes the whole pipeline.
`include "nv12_letterbox_to_rgb_unit_assert.svh"

module nv12_letterbox_to_rgb_unit #(
  parameter int MAX_SRC_WIDTH  = nlb_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = nlb_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int MAX_DST_SIZE   = nlb_pkg::MAX_DST_SIZE_DEF
) (
  input logic      clk,
  input logic      rst,
  nlb_in_if.sink   pixel,
  nlb_out_if.source result,
  nlb_cfg_if.sink  cfg
);

  localparam int DEPTH  = (MAX_SRC_WIDTH * MAX_SRC_HEIGHT * 3) / 2;
  localparam int S_IN   = 0;
  localparam int S_GEO  = 1;
  localparam int S_MUL  = 2;
  localparam int S_DIV0 = 3;
  localparam int S_CLMP = S_DIV0 + nlb_pkg::QW;
  localparam int S_AMUL = S_CLMP + 1;
  localparam int S_ADDR = S_AMUL + 1;
  localparam int N_ST   = S_ADDR + 1;

  // one pipeline slot; each stage fills the fields it owns
  typedef struct packed {
    logic                          vld;
    logic                          op;
    logic [nlb_pkg::ADDR_W-1:0]    addr;
    logic [nlb_pkg::BYTE_W-1:0]    val;
    logic [nlb_pkg::COORD_W-1:0]   dx;
    logic [nlb_pkg::COORD_W-1:0]   dy;
    logic                          pad;
    logic [nlb_pkg::PIDX_W-1:0]    pidx;
    logic [nlb_pkg::COORD_W-1:0]   rx;
    logic [nlb_pkg::COORD_W-1:0]   ry;
    logic [nlb_pkg::NUM_W-1:0]     remx;
    logic [nlb_pkg::NUM_W-1:0]     remy;
    logic [nlb_pkg::QW-1:0]        qx;
    logic [nlb_pkg::QW-1:0]        qy;
    logic [nlb_pkg::SRC_W-1:0]     sx;
    logic [nlb_pkg::SRC_W-1:0]     sy;
    logic [nlb_pkg::SRC_W-2:0]     ux;
    logic [nlb_pkg::SRC_W-2:0]     uy;
    logic [nlb_pkg::PLANE_W-1:0]   ya;
    logic [2*nlb_pkg::SRC_W-3:0]   uvr;
    logic [nlb_pkg::ADDR_W-1:0]    yaddr;
    logic [nlb_pkg::ADDR_W-1:0]    uvaddr;
  } item_t;

  typedef struct packed {
    logic                              vld;
    logic                              op;
    logic                              pad;
    logic [nlb_pkg::PIDX_W-1:0]        pidx;
    logic signed [nlb_pkg::PROD_W-1:0] yq;
    logic signed [nlb_pkg::PROD_W-1:0] prv;
    logic signed [nlb_pkg::PROD_W-1:0] pgu;
    logic signed [nlb_pkg::PROD_W-1:0] pgv;
    logic signed [nlb_pkg::PROD_W-1:0] pbu;
  } col_t;

  nlb_pkg::geo_t geo;
  item_t         st [N_ST];
  item_t         mem_it;
  col_t          col;
  logic          adv;
  logic          res_vld;
  logic [nlb_pkg::BYTE_W-1:0] y_byte, u_byte, v_byte;

  // geometry and configuration
  nlb_geometry #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .MAX_DST_SIZE  (MAX_DST_SIZE)
  ) u_geometry (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .geo(geo)
  );

  // whole pipeline moves when the output register is free or being drained
  assign adv         = !res_vld || result.ready;
  assign pixel.ready = adv && !geo.busy;

  // input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      st[S_IN].vld <= 1'b0;
    end else if (adv) begin
      st[S_IN]      <= st[S_IN];
      st[S_IN].vld  <= pixel.valid && pixel.ready;
      st[S_IN].op   <= pixel.op;
      st[S_IN].addr <= pixel.byte_address;
      st[S_IN].val  <= pixel.byte_value;
      st[S_IN].dx   <= pixel.dest_x;
      st[S_IN].dy   <= pixel.dest_y;
    end
  end

  // border test, offset removal and pixel index
  always_ff @(posedge clk) begin
    if (rst) begin
      st[S_GEO].vld <= 1'b0;
    end else if (adv) begin
      st[S_GEO]      <= st[S_IN];
      st[S_GEO].pad  <= (st[S_IN].dx < geo.ox)
                        || ({2'b0, st[S_IN].dx} >= ({2'b0, geo.ox} + 12'(geo.scw)))
                        || (st[S_IN].dy < geo.oy)
                        || ({2'b0, st[S_IN].dy} >= ({2'b0, geo.oy} + 12'(geo.sch)));
      st[S_GEO].pidx <= nlb_pkg::PIDX_W'(st[S_IN].dy * geo.dw + 21'(st[S_IN].dx));
      st[S_GEO].rx   <= st[S_IN].dx - geo.ox;
      st[S_GEO].ry   <= st[S_IN].dy - geo.oy;
    end
  end

  // scale numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      st[S_MUL].vld <= 1'b0;
    end else if (adv) begin
      st[S_MUL]      <= st[S_GEO];
      st[S_MUL].remx <= nlb_pkg::NUM_W'(st[S_GEO].rx * geo.sw);
      st[S_MUL].remy <= nlb_pkg::NUM_W'(st[S_GEO].ry * geo.sh);
      st[S_MUL].qx   <= '0;
      st[S_MUL].qy   <= '0;
    end
  end

  // pipelined restoring divide by the scaled size, msb first
  for (genvar k = 0; k < nlb_pkg::QW; k++) begin : g_div
    localparam int B = nlb_pkg::QW - 1 - k;
    localparam int DW2 = nlb_pkg::NUM_W + 1;
    logic [DW2-1:0] dxs, dys;
    item_t          nxt;

    assign dxs = DW2'(geo.scw) << B;
    assign dys = DW2'(geo.sch) << B;

    always_comb begin
      nxt = st[S_MUL + k];
      if ({1'b0, nxt.remx} >= dxs) begin
        nxt.remx  = nxt.remx - dxs[nlb_pkg::NUM_W-1:0];
        nxt.qx[B] = 1'b1;
      end
      if ({1'b0, nxt.remy} >= dys) begin
        nxt.remy  = nxt.remy - dys[nlb_pkg::NUM_W-1:0];
        nxt.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[S_DIV0 + k].vld <= 1'b0;
      end else if (adv) begin
        st[S_DIV0 + k] <= nxt;
      end
    end
  end

  // clamp source and chroma sample positions
  logic [nlb_pkg::SRC_W-1:0] cx, cy;
  logic [nlb_pkg::SRC_W-2:0] hw1, hh1;
  item_t                     div_out;

  assign div_out = st[S_CLMP - 1];
  assign cx  = (div_out.qx > geo.sw - 8'd1) ? geo.sw - 8'd1 : div_out.qx;
  assign cy  = (div_out.qy > geo.sh - 8'd1) ? geo.sh - 8'd1 : div_out.qy;
  assign hw1 = geo.sw[nlb_pkg::SRC_W-1:1] - 7'd1;
  assign hh1 = geo.sh[nlb_pkg::SRC_W-1:1] - 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st[S_CLMP].vld <= 1'b0;
    end else if (adv) begin
      st[S_CLMP]    <= div_out;
      st[S_CLMP].sx <= cx;
      st[S_CLMP].sy <= cy;
      st[S_CLMP].ux <= (cx[nlb_pkg::SRC_W-1:1] > hw1) ? hw1 : cx[nlb_pkg::SRC_W-1:1];
      st[S_CLMP].uy <= (cy[nlb_pkg::SRC_W-1:1] > hh1) ? hh1 : cy[nlb_pkg::SRC_W-1:1];
    end
  end

  // row products for the luma and chroma addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      st[S_AMUL].vld <= 1'b0;
    end else if (adv) begin
      st[S_AMUL]     <= st[S_CLMP];
      st[S_AMUL].ya  <= nlb_pkg::PLANE_W'(st[S_CLMP].sy * geo.sw);
      st[S_AMUL].uvr <= (2*nlb_pkg::SRC_W-2)'(st[S_CLMP].uy * geo.sw[nlb_pkg::SRC_W-1:1]);
    end
  end

  // final store addresses; chroma plane follows the luma plane
  always_ff @(posedge clk) begin
    if (rst) begin
      st[S_ADDR].vld <= 1'b0;
    end else if (adv) begin
      st[S_ADDR]        <= st[S_AMUL];
      st[S_ADDR].yaddr  <= nlb_pkg::ADDR_W'(st[S_AMUL].ya + 16'(st[S_AMUL].sx));
      st[S_ADDR].uvaddr <= nlb_pkg::ADDR_W'(18'(geo.plane)
                           + ((18'(st[S_AMUL].uvr) + 18'(st[S_AMUL].ux)) << 1));
    end
  end

  // store access: writes and reads happen at the same stage, keeping beat order
  nlb_frame_store #(
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk    (clk),
    .en     (adv),
    .we     (st[S_ADDR].vld && (st[S_ADDR].op == nlb_pkg::OP_WRITE)),
    .waddr  (st[S_ADDR].addr),
    .wdata  (st[S_ADDR].val),
    .y_addr (st[S_ADDR].yaddr),
    .uv_addr(st[S_ADDR].uvaddr),
    .y_byte (y_byte),
    .u_byte (u_byte),
    .v_byte (v_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_it.vld <= 1'b0;
    end else if (adv) begin
      mem_it <= st[S_ADDR];
    end
  end

  // colour products in q.14
  logic signed [nlb_pkg::BYTE_W:0] du, dv;

  assign du = $signed({1'b0, u_byte}) - 9'sd128;
  assign dv = $signed({1'b0, v_byte}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      col.vld <= 1'b0;
    end else if (adv) begin
      col.vld  <= mem_it.vld;
      col.op   <= mem_it.op;
      col.pad  <= mem_it.pad;
      col.pidx <= mem_it.pidx;
      col.yq   <= $signed({3'b0, y_byte, 14'b0});
      col.prv  <= nlb_pkg::COEF_RV * dv;
      col.pgu  <= nlb_pkg::COEF_GU * du;
      col.pgv  <= nlb_pkg::COEF_GV * dv;
      col.pbu  <= nlb_pkg::COEF_BU * du;
    end
  end

  // sums, clamp and rounding into the output register
  logic signed [nlb_pkg::ACC_W-1:0] acc_r, acc_g, acc_b;
  logic                             zero_col;

  assign acc_r = nlb_pkg::ACC_W'(col.yq) + nlb_pkg::ACC_W'(col.prv);
  assign acc_g = nlb_pkg::ACC_W'(col.yq) - nlb_pkg::ACC_W'(col.pgu)
                 - nlb_pkg::ACC_W'(col.pgv);
  assign acc_b = nlb_pkg::ACC_W'(col.yq) + nlb_pkg::ACC_W'(col.pbu);
  assign zero_col = col.pad || !geo.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld            <= col.vld && (col.op == nlb_pkg::OP_CONVERT);
      result.red         <= zero_col ? '0 : nlb_pkg::to_q88(acc_r);
      result.green       <= zero_col ? '0 : nlb_pkg::to_q88(acc_g);
      result.blue        <= zero_col ? '0 : nlb_pkg::to_q88(acc_b);
      result.is_padding  <= geo.ok && col.pad;
      result.pixel_index <= geo.ok ? col.pidx : '0;
      result.size_error  <= !geo.ok;
    end
  end

  assign result.valid = res_vld;

  // invalid sizes give an all-zero result
  `NLB_ASSERT_NOW(a_err_zero, result.valid && result.size_error, (result.red == '0) && (result.pixel_index == '0) && !result.is_padding, "size error result not zeroed")
  // border pixels carry no colour
  `NLB_ASSERT_NOW(a_pad_zero, result.valid && result.is_padding, (result.red == '0) && (result.green == '0) && (result.blue == '0), "padding pixel has colour")
  // derived picture fits the destination on at least one full axis
  `NLB_ASSERT_NOW(a_fit, !geo.busy && geo.ok, (geo.scw <= geo.dw) && (geo.sch <= geo.dh) && ((geo.scw == geo.dw) || (geo.sch == geo.dh)), "letterbox geometry out of range")
  // a register write always restarts the derivation
  `NLB_ASSERT_NEXT(a_cfg_busy, cfg.valid && cfg.ready, geo.busy && !pixel.ready, "config write did not rederive geometry")

endmodule

// ===== design/nlb_frame_store.sv =====
// two-bank byte store: even and odd addresses, each with one write and two reads
module nlb_frame_store #(
  parameter int DEPTH = 24576
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [nlb_pkg::ADDR_W-1:0]  waddr,
  input  logic [nlb_pkg::BYTE_W-1:0]  wdata,
  input  logic [nlb_pkg::ADDR_W-1:0]  y_addr,
  input  logic [nlb_pkg::ADDR_W-1:0]  uv_addr,
  output logic [nlb_pkg::BYTE_W-1:0]  y_byte,
  output logic [nlb_pkg::BYTE_W-1:0]  u_byte,
  output logic [nlb_pkg::BYTE_W-1:0]  v_byte
);

  localparam int BANK_D = (DEPTH + 1) / 2;
  localparam int BW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  logic [nlb_pkg::BYTE_W-1:0] bank_even [BANK_D];
  logic [nlb_pkg::BYTE_W-1:0] bank_odd  [BANK_D];
  logic [nlb_pkg::BYTE_W-1:0] even_y, even_uv, odd_y, odd_uv;
  logic                       y_odd;
  logic [BW-1:0]              widx, yidx, uvidx;

  assign widx  = BW'(waddr >> 1);
  assign yidx  = BW'(y_addr >> 1);
  assign uvidx = BW'(uv_addr >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (we && (32'(waddr) < DEPTH)) begin
        if (waddr[0]) bank_odd[widx] <= wdata;
        else bank_even[widx] <= wdata;
      end
      even_y  <= bank_even[yidx];
      even_uv <= bank_even[uvidx];
      odd_y   <= bank_odd[yidx];
      odd_uv  <= bank_odd[uvidx];
      y_odd   <= y_addr[0];
    end
  end

  // chroma pair always starts on an even address
  assign y_byte = y_odd ? odd_y : even_y;
  assign u_byte = even_uv;
  assign v_byte = odd_uv;

endmodule

// ===== design/nlb_geometry.sv =====
// configuration registers and sequential derivation of the letterbox geometry
module nlb_geometry #(
  parameter int MAX_SRC_WIDTH  = nlb_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = nlb_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int MAX_DST_SIZE   = nlb_pkg::MAX_DST_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  nlb_cfg_if.sink       cfg,
  output nlb_pkg::geo_t geo
);

  localparam int GQ   = nlb_pkg::DST_W;
  localparam int CW   = $clog2(GQ);
  localparam int GN_W = nlb_pkg::DST_W + nlb_pkg::SRC_W;

  typedef enum logic [3:0] {
    G_IDLE  = 4'b0001,
    G_CHECK = 4'b0010,
    G_DIV   = 4'b0100,
    G_FIN   = 4'b1000
  } gstate_t;

  gstate_t                       state;
  logic [nlb_pkg::SRC_W-1:0]     sw, sh;
  logic [nlb_pkg::DST_W-1:0]     dw, dh;
  logic                          sel_w;
  logic [GN_W-1:0]               rem, dsh, pa, pb;
  logic [GQ-1:0]                 quot, q1;
  logic [CW-1:0]                 cnt;
  logic                          ok;
  logic [nlb_pkg::DST_W-1:0]     scw, sch;
  logic [nlb_pkg::COORD_W-1:0]   ox, oy;
  logic [nlb_pkg::PLANE_W-1:0]   plane;
  logic                          sizes_ok;

  assign cfg.ready = 1'b1;

  assign pa = GN_W'(dw * sh);
  assign pb = GN_W'(dh * sw);
  assign q1 = (quot == '0) ? GQ'(1) : quot;

  assign sizes_ok = (sw != '0) && (sh != '0) && !sw[0] && !sh[0]
                    && (32'(sw) <= MAX_SRC_WIDTH) && (32'(sh) <= MAX_SRC_HEIGHT)
                    && (dw != '0) && (dh != '0)
                    && (32'(dw) <= MAX_DST_SIZE) && (32'(dh) <= MAX_DST_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_CHECK;
      sw    <= nlb_pkg::RESET_SRC;
      sh    <= nlb_pkg::RESET_SRC;
      dw    <= nlb_pkg::RESET_DST;
      dh    <= nlb_pkg::RESET_DST;
      ok    <= 1'b0;
    end else begin
      case (state)
        G_IDLE: begin
        end
        G_CHECK: begin
          plane <= nlb_pkg::PLANE_W'(sw * sh);
          if (!sizes_ok) begin
            ok    <= 1'b0;
            scw   <= '0;
            sch   <= '0;
            ox    <= '0;
            oy    <= '0;
            state <= G_IDLE;
          end else begin
            // fit to width when dw/sw is the smaller ratio or the ratios are equal
            sel_w <= (pa <= pb);
            rem   <= (pa <= pb) ? pa : pb;
            dsh   <= (pa <= pb) ? (GN_W'(sw) << (GQ - 1)) : (GN_W'(sh) << (GQ - 1));
            quot  <= '0;
            cnt   <= CW'(GQ - 1);
            state <= G_DIV;
          end
        end
        G_DIV: begin
          if (rem >= dsh) begin
            rem       <= rem - dsh;
            quot[cnt] <= 1'b1;
          end
          dsh <= dsh >> 1;
          cnt <= cnt - CW'(1);
          if (cnt == '0) state <= G_FIN;
        end
        G_FIN: begin
          if (sel_w) begin
            scw <= dw;
            sch <= q1;
            ox  <= '0;
            oy  <= nlb_pkg::COORD_W'((dh - q1) >> 1);
          end else begin
            scw <= q1;
            sch <= dh;
            ox  <= nlb_pkg::COORD_W'((dw - q1) >> 1);
            oy  <= '0;
          end
          ok    <= 1'b1;
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
      if (cfg.valid) begin
        case (nlb_pkg::reg_idx_t'(cfg.index))
          nlb_pkg::REG_SOURCE_WIDTH:  sw <= cfg.data[nlb_pkg::SRC_W-1:0];
          nlb_pkg::REG_SOURCE_HEIGHT: sh <= cfg.data[nlb_pkg::SRC_W-1:0];
          nlb_pkg::REG_DEST_WIDTH:    dw <= cfg.data;
          nlb_pkg::REG_DEST_HEIGHT:   dh <= cfg.data;
          default: sw <= sw;
        endcase
        state <= G_CHECK;
      end
    end
  end

  always_comb begin
    geo.busy  = (state != G_IDLE);
    geo.ok    = ok;
    geo.sw    = sw;
    geo.sh    = sh;
    geo.dw    = dw;
    geo.dh    = dh;
    geo.scw   = scw;
    geo.sch   = sch;
    geo.ox    = ox;
    geo.oy    = oy;
    geo.plane = plane;
  end

endmodule
